// ===== hdl/accel_offset_autocalibrate_macros.svh =====
// Assertion macros shared by the accelerometer offset calibration RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ACCEL_OFFSET_AUTOCALIBRATE_MACROS_SVH
`define ACCEL_OFFSET_AUTOCALIBRATE_MACROS_SVH

// same-cycle implication
`define AOC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AOC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// delayed implication
`define AOC_ASSERT_LATER3(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##3 (cons)) \
      else $error(msg);

`endif

// ===== hdl/aoc_pkg.sv =====
// Shared types and constants for the accelerometer offset calibration block.
// No dependencies.
package aoc_pkg;

   localparam int DATA_W           = 16;
   localparam int AXES             = 3;
   localparam int AOC_SAMPLE_COUNT = 256;

   typedef logic signed [DATA_W-1:0] sample_type;

endpackage

// ===== hdl/aoc_recip_div.sv =====
// Pipelined signed division of an axis sum by the constant sample count.
// Reciprocal multiply, truncating toward zero; two register stages. Uses aoc_pkg.
module aoc_recip_div import aoc_pkg::*; #(
   parameter int SAMPLE_COUNT = AOC_SAMPLE_COUNT
) (
   input  logic                                           clock,
   input  logic signed [DATA_W+$clog2(SAMPLE_COUNT)-1:0]  sum_in,
   output sample_type                                     quot_out
);

   localparam int L     = $clog2(SAMPLE_COUNT);
   localparam int SUM_W = DATA_W + L;
   localparam int SHIFT = SUM_W + L;
   localparam int MAG_W = DATA_W + 1;
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) / 64'(SAMPLE_COUNT)) + 64'd1;
   localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

   logic [SUM_W-1:0]  abs_ff, abs_in;
   logic              sign_ff, sign2_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MAG_W-1:0]  mag;
   logic [MAG_W-1:0]  quot_wide;

   assign abs_in  = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
   assign prod_in = {{(SUM_W+1){1'b0}}, abs_ff} * {{SUM_W{1'b0}}, RECIP};

   always_ff @(posedge clock) begin
      abs_ff   <= abs_in;
      sign_ff  <= sum_in[SUM_W-1];
      prod_ff  <= prod_in;
      sign2_ff <= sign_ff;
   end

   assign mag       = prod_ff[SHIFT +: MAG_W];
   assign quot_wide = sign2_ff ? (MAG_W'(0) - mag) : mag;
   assign quot_out  = sample_type'(quot_wide[DATA_W-1:0]);

endmodule

// ===== hdl/accel_offset_autocalibrate.sv =====
// Accelerometer offset calibration: subtracts per-axis offsets (not in raw mode) learned by
// averaging the first SAMPLE_COUNT samples after reset. Takes one word per clock while the
// result side is not stalled; after the word that completes calibration, words wait in the
// input register through S_ABS, S_MUL and S_APPLY while the two-stage reciprocal-multiply
// divider turns the axis sums into offsets and the offsets load. An input register and a
// result register part the two channels, so a new word is taken while a result waits.
`include "accel_offset_autocalibrate_macros.svh"

module accel_offset_autocalibrate import aoc_pkg::*; #(
   parameter int SAMPLE_COUNT = AOC_SAMPLE_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample_x,
   input  sample_type req_sample_y,
   input  sample_type req_sample_z,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_corrected_x,
   output sample_type rsp_corrected_y,
   output sample_type rsp_corrected_z,
   output logic       rsp_offsets_valid,
   output logic       rsp_calibration_done
);

   localparam int L     = $clog2(SAMPLE_COUNT);
   localparam int SUM_W = DATA_W + L;
   localparam int CNT_W = (SAMPLE_COUNT > 1) ? L : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_COUNT - 1);

   typedef enum logic [2:0] {
      S_RUN, S_ABS, S_MUL, S_APPLY, S_CAL
   } cal_state_type;

   typedef logic signed [SUM_W-1:0] sum_type;

   cal_state_type    state_ff;
   logic             raw_mode_ff;
   logic [CNT_W-1:0] count_ff;
   logic             in_valid_ff;
   sample_type       in_sample_ff [AXES];
   sum_type          sum_ff       [AXES];
   sum_type          sum_in       [AXES];
   sample_type       offset_ff    [AXES];
   sample_type       quot         [AXES];
   sample_type       corr_in      [AXES];
   sample_type       rsp_corr_ff  [AXES];
   logic             rsp_valid_ff;
   logic             rsp_offsets_valid_ff;
   logic             rsp_done_ff;
   logic             can_work;
   logic             advance;
   logic             last_word;

   assign can_work  = (state_ff == S_RUN) || (state_ff == S_CAL);
   assign advance   = in_valid_ff && can_work && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign last_word = (state_ff == S_RUN) && (count_ff == LAST_CNT);

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      assign corr_in[a] = raw_mode_ff ? in_sample_ff[a] : in_sample_ff[a] - offset_ff[a];
      assign sum_in[a]  = ((count_ff == '0) ? sum_type'(0) : sum_ff[a])
                          + sum_type'(corr_in[a]);

      aoc_recip_div #(
         .SAMPLE_COUNT (SAMPLE_COUNT)
      ) u_div (
         .clock    (clock),
         .sum_in   (sum_ff[a]),
         .quot_out (quot[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_RUN;
         raw_mode_ff          <= 1'b0;
         count_ff             <= '0;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         rsp_offsets_valid_ff <= 1'b0;
         rsp_done_ff          <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            offset_ff[a] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            raw_mode_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_RUN: begin
               if (advance) begin
                  count_ff <= last_word ? '0 : count_ff + CNT_W'(1);
                  if (last_word) begin
                     state_ff <= S_ABS;
                  end
               end
            end
            S_ABS:   state_ff <= S_MUL;
            S_MUL:   state_ff <= S_APPLY;
            S_APPLY: begin
               for (int a = 0; a < AXES; a++) begin
                  offset_ff[a] <= quot[a];
               end
               state_ff <= S_CAL;
            end
            S_CAL:   state_ff <= S_CAL;
            default: state_ff <= S_RUN;
         endcase
         if (advance) begin
            rsp_offsets_valid_ff <= (state_ff == S_CAL) || last_word;
            rsp_done_ff          <= last_word;
         end
      end
   end

   // payload registers: load input word, accumulate, capture result
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_sample_ff[0] <= req_sample_x;
         in_sample_ff[1] <= req_sample_y;
         in_sample_ff[2] <= req_sample_z;
      end
      for (int a = 0; a < AXES; a++) begin
         if (advance && (state_ff == S_RUN)) begin
            sum_ff[a] <= sum_in[a];
         end
         if (advance) begin
            rsp_corr_ff[a] <= corr_in[a];
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_corrected_x      = rsp_corr_ff[0];
   assign rsp_corrected_y      = rsp_corr_ff[1];
   assign rsp_corrected_z      = rsp_corr_ff[2];
   assign rsp_offsets_valid    = rsp_offsets_valid_ff;
   assign rsp_calibration_done = rsp_done_ff;

   `AOC_ASSERT_NOW(a_done_implies_valid, rsp_valid_ff && rsp_done_ff, rsp_offsets_valid_ff, "calibration_done without offsets_valid")
   `AOC_ASSERT_LATER3(a_apply_after_last, advance && last_word, state_ff == S_APPLY, "offsets not applied three cycles after the last calibration word")
   `AOC_ASSERT_NEXT(a_offsets_stable, state_ff != S_APPLY, offset_ff[0] == $past(offset_ff[0]) && offset_ff[1] == $past(offset_ff[1]) && offset_ff[2] == $past(offset_ff[2]), "offsets changed outside the apply step")
   `AOC_ASSERT_NEXT(a_word_moves, in_valid_ff && !rsp_valid_ff && can_work, rsp_valid_ff, "held word did not reach the result register")

endmodule

// ===== tb/accel_offset_autocalibrate_tb.sv =====
// Testbench for accel_offset_autocalibrate: drives sample words and checks every result word
// against an in-bench calibration and correction predictor. Depends on aoc_pkg and the RTL.
`timescale 1ns / 100ps

module accel_offset_autocalibrate_tb;
   import aoc_pkg::*;

   localparam int HOLD_CYCLES = 80;

   typedef struct {
      sample_type corr [AXES];
      logic       offsets_valid;
      logic       cal_done;
   } corrected_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   sample_type req_sample_x = '0;
   sample_type req_sample_y = '0;
   sample_type req_sample_z = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   sample_type rsp_corrected_x;
   sample_type rsp_corrected_y;
   sample_type rsp_corrected_z;
   logic       rsp_offsets_valid;
   logic       rsp_calibration_done;

   // predictor state
   logic              raw_mode_q = 1'b0;
   logic              calibrated_q = 1'b0;
   int                samples_taken_q = 0;
   logic signed [27:0] axis_sum_q [AXES] = '{default: '0};
   sample_type        axis_offset_q [AXES] = '{default: '0};

   corrected_word_type expected_words [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   accel_offset_autocalibrate dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_x        (req_sample_x),
      .req_sample_y        (req_sample_y),
      .req_sample_z        (req_sample_z),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_corrected_x     (rsp_corrected_x),
      .rsp_corrected_y     (rsp_corrected_y),
      .rsp_corrected_z     (rsp_corrected_z),
      .rsp_offsets_valid   (rsp_offsets_valid),
      .rsp_calibration_done(rsp_calibration_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic corrected_word_type predict_corrected(input sample_type sx, sy, sz);
      corrected_word_type w;
      sample_type s [AXES];
      int q;
      s[0] = sx;
      s[1] = sy;
      s[2] = sz;
      w.cal_done = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         if (raw_mode_q)
            w.corr[i] = s[i];
         else
            w.corr[i] = sample_type'(s[i] - axis_offset_q[i]);
      end
      if (!calibrated_q) begin
         if (samples_taken_q == 0) begin
            for (int i = 0; i < AXES; i++) begin
               axis_sum_q[i] = '0;
               axis_offset_q[i] = '0;
            end
         end
         for (int i = 0; i < AXES; i++)
            axis_sum_q[i] = axis_sum_q[i] + w.corr[i];
         samples_taken_q++;
         if (samples_taken_q >= AOC_SAMPLE_COUNT) begin
            for (int i = 0; i < AXES; i++) begin
               q = int'(axis_sum_q[i]) / AOC_SAMPLE_COUNT;
               axis_offset_q[i] = sample_type'(q);
            end
            samples_taken_q = 0;
            calibrated_q = 1'b1;
            w.cal_done = 1'b1;
         end
      end
      w.offsets_valid = calibrated_q;
      return w;
   endfunction

   // receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string field, input logic signed [15:0] want,
                              input logic signed [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      corrected_word_type w;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("result word with no expected word pending");
            error_count++;
         end else begin
            w = expected_words.pop_front();
            check_field("corrected_x", w.corr[0], rsp_corrected_x);
            check_field("corrected_y", w.corr[1], rsp_corrected_y);
            check_field("corrected_z", w.corr[2], rsp_corrected_z);
            check_field("offsets_valid", 16'(w.offsets_valid), 16'(rsp_offsets_valid));
            check_field("calibration_done", 16'(w.cal_done), 16'(rsp_calibration_done));
         end
      end
   end

   task automatic send_sample(input sample_type sx, sy, sz);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_x <= sx;
      req_sample_y <= sy;
      req_sample_z <= sz;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_words.push_back(predict_corrected(sx, sy, sz));
   endtask

   task automatic send_random_sample();
      send_sample(sample_type'($urandom), sample_type'($urandom), sample_type'($urandom));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_raw_mode(input logic mode);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      raw_mode_q = mode;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // extremes while calibrating, in both modes
   task automatic test_calibration_directed();
      set_idling(0, 0);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh0000, 16'sh0000, 16'sh0000);
      send_sample(16'shffff, 16'shffff, 16'shffff);
      send_sample(16'sh0001, 16'sh0001, 16'sh0001);
      send_sample(16'sh7fff, 16'sh8000, 16'sh0000);
      send_sample(16'sh5555, 16'shaaaa, 16'sh8000);
      write_raw_mode(1'b1);
      send_sample(16'sh8000, 16'sh7fff, 16'shffff);
      send_sample(16'shaaaa, 16'sh5555, 16'sh7fff);
      write_raw_mode(1'b0);
   endtask

   // biased samples until the window closes; negative biases exercise truncation
   task automatic test_calibration_fill();
      int bias [AXES];
      int val [AXES];
      for (int i = 0; i < AXES; i++)
         bias[i] = int'($urandom_range(0, 24000)) - 12000;
      set_idling(25, 25);
      while (!calibrated_q) begin
         for (int i = 0; i < AXES; i++)
            val[i] = bias[i] + int'($urandom_range(0, 600)) - 300;
         send_sample(sample_type'(val[0]), sample_type'(val[1]), sample_type'(val[2]));
      end
   endtask

   // wrap-around of corrected extremes, and raw mode after calibration
   task automatic test_corrected_extremes();
      set_idling(0, 0);
      write_raw_mode(1'b0);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh0000, 16'sh0000, 16'sh0000);
      send_sample(axis_offset_q[0], axis_offset_q[1], axis_offset_q[2]);
      write_raw_mode(1'b1);
      send_sample(16'sh8000, 16'sh7fff, 16'sh0000);
      send_sample(16'sh7fff, 16'sh8000, 16'shffff);
      write_raw_mode(1'b0);
   endtask

   task automatic test_random_phases();
      int send_pct [4] = '{0, 54, 0, 25};
      int recv_pct [4] = '{0, 0, 54, 25};
      for (int p = 0; p < 4; p++) begin
         write_raw_mode(logic'(p % 2));
         set_idling(send_pct[p], recv_pct[p]);
         repeat (40) send_random_sample();
      end
      write_raw_mode(1'b0);
   endtask

   // hold the receiver off while the sender keeps offering words
   task automatic test_backpressure();
      drain_results();
      set_idling(0, 0);
      hold_request = 1'b1;
      repeat (30) send_random_sample();
      set_idling(25, 25);
      repeat (20) send_random_sample();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_raw_mode(1'b0);
      test_calibration_directed();
      test_calibration_fill();
      test_corrected_extremes();
      test_random_phases();
      test_backpressure();
      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
